>>> hw/rtl/mp2s_pkg.sv
// shared types, constants and compare functions for the maximal points block
package mp2s_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W    = 16;

  typedef logic signed [COORD_W-1:0] coord_t;

  // data handed between neighboring cells
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   vld;       // cell holds a point
    logic   kill;      // point is dominated (current)
    logic   kill_upd;  // kill including the point being inserted now
    logic   after;     // held point sorts after the arriving point
    logic   dom_new;   // held point dominates the arriving point
  } link_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   insert;    // store the arriving point this cycle
    logic   shift;     // move every point one cell toward cell 0
    coord_t new_x;
    coord_t new_y;
    logic   new_kill;  // arriving point is dominated by a held one
  } ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  // a sorts after b: x ascending, then y ascending
  function automatic logic comes_after(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    comes_after = (ax > bx) || ((ax == bx) && (ay > by));
  endfunction

  // a is at least b in both coordinates
  function automatic logic covers(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    covers = (ax >= bx) && (ay >= by);
  endfunction

endpackage

>>> hw/rtl/mp2s_cell.sv
// one cell of the sorted point chain: holds a point and its dominated flag
module mp2s_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mp2s_pkg::ctl_t    ctl_i,
  input  mp2s_pkg::link_t   lft_i,
  input  mp2s_pkg::link_t   rgt_i,
  output mp2s_pkg::link_t   cell_o
);
  import mp2s_pkg::*;

  coord_t x_q, x_d;
  coord_t y_q, y_d;
  logic   vld_q, vld_d;
  logic   kill_q, kill_d;
  logic   after;
  logic   kill_upd;

  // compares against the arriving point
  assign after    = vld_q & comes_after(x_q, y_q, ctl_i.new_x, ctl_i.new_y);
  assign kill_upd = kill_q | (vld_q & covers(ctl_i.new_x, ctl_i.new_y, x_q, y_q));

  assign cell_o.x        = x_q;
  assign cell_o.y        = y_q;
  assign cell_o.vld      = vld_q;
  assign cell_o.kill     = kill_q;
  assign cell_o.kill_upd = kill_upd;
  assign cell_o.after    = after;
  assign cell_o.dom_new  = vld_q & covers(x_q, y_q, ctl_i.new_x, ctl_i.new_y);

  // next cell content: shift out, make room, take the new point or keep
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    vld_d  = vld_q;
    kill_d = kill_q;
    if (ctl_i.shift) begin
      x_d    = rgt_i.x;
      y_d    = rgt_i.y;
      vld_d  = rgt_i.vld;
      kill_d = rgt_i.kill;
    end else if (ctl_i.insert) begin
      if (lft_i.after) begin
        x_d    = lft_i.x;
        y_d    = lft_i.y;
        vld_d  = 1'b1;
        kill_d = lft_i.kill_upd;
      end else if ((!vld_q || after) && lft_i.vld) begin
        x_d    = ctl_i.new_x;
        y_d    = ctl_i.new_y;
        vld_d  = 1'b1;
        kill_d = ctl_i.new_kill;
      end else begin
        kill_d = kill_upd;
      end
    end
  end

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      kill_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      kill_q <= kill_d;
    end
  end

  // point payload
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

endmodule

>>> hw/rtl/maximal_points_2d_sorted.sv
// Maximal points of a 2D point set, found in a sorted chain of 64 cells.
// Points load one per cycle (start_i while busy_o is low): each arriving
// point is compared against every held point at once, inserted in x-then-y
// order, and dominated points are marked. The point with set_end_i closes
// the set; busy_o then stays high while the chain shifts out through
// cell 0, and the maximal points appear in sorted order, one per
// res_valid_o pulse, the last with final_result_o. A set with no maximal
// point gives a single pulse with none_found_o and zero coordinates.
// Points past 64 are dropped and every result of that set carries
// overflow_o. Results are one-cycle strobes; the receiver cannot stall
// them.
module maximal_points_2d_sorted (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic signed [15:0]    pt_x_i,
  input  logic signed [15:0]    pt_y_i,
  input  logic                  set_end_i,
  output logic                  res_valid_o,
  output logic signed [15:0]    max_x_o,
  output logic signed [15:0]    max_y_o,
  output logic                  final_result_o,
  output logic                  none_found_o,
  output logic                  overflow_o
);
  import mp2s_pkg::*;

  localparam link_t LEFT_END  = '{x: '0, y: '0, vld: 1'b1, kill: 1'b0, kill_upd: 1'b0,
                                  after: 1'b0, dom_new: 1'b0};
  localparam link_t RIGHT_END = '{x: '0, y: '0, vld: 1'b0, kill: 1'b0, kill_upd: 1'b0,
                                  after: 1'b0, dom_new: 1'b0};

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 drop_q, drop_d;
  coord_t               pend_x_q, pend_y_q;
  logic                 pend_vld_q, pend_vld_d;
  logic                 res_vld_q, res_vld_d;
  coord_t               res_x_q, res_x_d, res_y_q, res_y_d;
  logic                 res_fin_q, res_fin_d, res_none_q, res_none_d;
  logic                 ovf_q;
  logic                 accept;
  logic                 head_alive;
  ctl_t                 ctl;
  link_t                lnk [MAX_POINTS];
  logic [MAX_POINTS-1:0] dom_vec;
  logic [MAX_POINTS-1:0] vld_vec;

  assign busy_o = (state_q == ST_EMIT);
  assign accept = start_i && !busy_o;

  // broadcast control for the cell chain
  assign ctl.insert   = accept && (count_q < CNT_W'(MAX_POINTS));
  assign ctl.shift    = (state_q == ST_EMIT);
  assign ctl.new_x    = pt_x_i;
  assign ctl.new_y    = pt_y_i;
  assign ctl.new_kill = |dom_vec;

  // chain of cells, cell 0 holds the smallest point
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    link_t lft, rgt;
    if (k == 0) begin : g_first
      assign lft = LEFT_END;
    end else begin : g_mid_l
      assign lft = lnk[k-1];
    end
    if (k == MAX_POINTS - 1) begin : g_last
      assign rgt = RIGHT_END;
    end else begin : g_mid_r
      assign rgt = lnk[k+1];
    end
    mp2s_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .lft_i  (lft),
      .rgt_i  (rgt),
      .cell_o (lnk[k])
    );
    assign dom_vec[k] = lnk[k].dom_new;
    assign vld_vec[k] = lnk[k].vld;
  end

  assign head_alive = lnk[0].vld && !lnk[0].kill;

  // load and emission control; results leave one behind the head
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    drop_d     = drop_q;
    pend_vld_d = pend_vld_q;
    res_vld_d  = 1'b0;
    res_x_d    = pend_x_q;
    res_y_d    = pend_y_q;
    res_fin_d  = 1'b0;
    res_none_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (ctl.insert) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (set_end_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (lnk[0].vld) begin
          if (head_alive) begin
            res_vld_d  = pend_vld_q;
            pend_vld_d = 1'b1;
          end
        end else begin
          res_vld_d  = 1'b1;
          res_fin_d  = 1'b1;
          res_none_d = !pend_vld_q;
          if (!pend_vld_q) begin
            res_x_d = '0;
            res_y_d = '0;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_LOAD;
          count_d    = '0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      drop_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
      if (state_q == ST_EMIT && !lnk[0].vld) begin
        drop_q <= 1'b0;
      end else begin
        drop_q <= drop_d;
      end
    end
  end

  // result and pending payload
  always_ff @(posedge clk_i) begin
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    res_fin_q  <= res_fin_d;
    res_none_q <= res_none_d;
    if (state_q == ST_EMIT) begin
      ovf_q <= drop_q;
    end
    if (state_q == ST_EMIT && head_alive) begin
      pend_x_q <= lnk[0].x;
      pend_y_q <= lnk[0].y;
    end
  end

  assign res_valid_o    = res_vld_q;
  assign max_x_o        = res_x_q;
  assign max_y_o        = res_y_q;
  assign final_result_o = res_fin_q;
  assign none_found_o   = res_none_q;
  assign overflow_o     = ovf_q;

`ifndef ASSERT_OFF
  // held points stay packed toward cell 0
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_vec & (vld_vec + MAX_POINTS'(1))) == '0)
    else $error("cell chain not packed");

  // fill count matches the occupied cells while loading
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> $countones(vld_vec) == 32'(count_q))
    else $error("fill count mismatch");

  // an empty answer is always the closing result
  a_none_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && none_found_o |-> final_result_o)
    else $error("none_found without final_result");

  // the closing result leaves the chain empty and ready to load
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && final_result_o |-> state_q == ST_LOAD && vld_vec == '0 && !pend_vld_q)
    else $error("block not idle after final result");
`endif

endmodule
